// ===== hdl/ring_message_queue_remove_at_unit_defines.svh =====
// Assertion macros shared by the ring message queue RTL.
// Each macro expects signals named clk and rst in the including module.
`ifndef RING_MESSAGE_QUEUE_REMOVE_AT_UNIT_DEFINES_SVH
`define RING_MESSAGE_QUEUE_REMOVE_AT_UNIT_DEFINES_SVH

// Plain property checked at every clock edge outside reset.
`define RMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define RMQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RMQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rmq_pkg.sv =====
// Shared constants, command codes, control structs and index helper for the
// ring message queue. No dependencies.
package rmq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int MSG_WIDTH_DEF = 32;

  localparam int CMD_W   = 3;
  localparam int OFF_W   = 4;
  localparam int MSG_F_W = 32;
  localparam int CNT_W   = 5;
  localparam int SUM_W   = CNT_W + 1;

  localparam int CAP_RESET = 16;

  localparam logic [CMD_W-1:0] CMD_PUSH      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PEEK      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ_AT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE_AT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;

  typedef struct packed {
    logic accept;
    logic exec;
    logic shift;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_shift;
    logic last_shift;
  } dp_sts_t;

  // Ring index wrap: subtracts the capacity once, so the result is in range only for sums below twice the capacity.
  function automatic logic [CNT_W-1:0] wrap_idx(input logic [SUM_W-1:0] sum,
                                                input logic [CNT_W-1:0] cap);
    logic [SUM_W-1:0] cap_ext;
    cap_ext = SUM_W'(cap);
    if (sum >= cap_ext) begin
      return CNT_W'(sum - cap_ext);
    end
    return CNT_W'(sum);
  endfunction

endpackage

// ===== hdl/rmq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on rmq_pkg for its parameter defaults.
module rmq_ram #(
  parameter int WIDTH = rmq_pkg::MSG_WIDTH_DEF,
  parameter int DEPTH = rmq_pkg::DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/rmq_ctrl.sv =====
// Command sequencer for the ring message queue: handshakes and step control.
// Depends on rmq_pkg and the assertion macro header.
`include "ring_message_queue_remove_at_unit_defines.svh"

module rmq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output rmq_pkg::ctrl_cmd_t ctl,
  input  rmq_pkg::dp_sts_t   sts
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready     = (state == S_IDLE);
  assign ctl.accept   = in_valid && in_ready;
  assign ctl.exec     = (state == S_EXEC);
  assign ctl.shift    = (state == S_SHIFT);
  assign ctl.load_out = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (ctl.accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = sts.need_shift ? S_SHIFT : S_DONE;
      end
      S_SHIFT: begin
        if (sts.last_shift) state_next = S_DONE;
      end
      S_DONE: begin
        if (ctl.load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `RMQ_ASSERT_NXT(a_accept_to_exec, in_valid && in_ready, state == S_EXEC, "accept did not start execution")
  `RMQ_ASSERT_IMP(a_shift_origin, state == S_SHIFT, $past(state) == S_EXEC || $past(state) == S_SHIFT, "shift entered from wrong state")
  `RMQ_ASSERT_NXT(a_done_holds, state == S_DONE && out_valid && !out_ready, state == S_DONE, "result dropped while output stalled")

endmodule

// ===== hdl/rmq_dp.sv =====
// Datapath of the ring message queue: head, count, capacity, message store,
// ring index arithmetic and result registers. Depends on rmq_pkg, rmq_ram
// and the assertion macro header.
`include "ring_message_queue_remove_at_unit_defines.svh"

module rmq_dp #(
  parameter int DEPTH     = rmq_pkg::DEPTH_DEF,
  parameter int MSG_WIDTH = rmq_pkg::MSG_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rmq_pkg::ctrl_cmd_t                ctl,
  output rmq_pkg::dp_sts_t                  sts,
  input  logic                              cfg_we,
  input  logic [rmq_pkg::CNT_W-1:0]         cfg_wdata,
  input  logic [rmq_pkg::CMD_W-1:0]         command,
  input  logic [rmq_pkg::OFF_W-1:0]         offset,
  input  logic [rmq_pkg::MSG_F_W-1:0]       message_in,
  output logic                              ok,
  output logic [rmq_pkg::MSG_F_W-1:0]       message_out,
  output logic [rmq_pkg::CNT_W-1:0]         count_now
);

  localparam int CNT_W   = rmq_pkg::CNT_W;
  localparam int SUM_W   = rmq_pkg::SUM_W;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CAP_MAX = (DEPTH < (2**CNT_W - 1)) ? DEPTH : (2**CNT_W - 1);
  localparam logic [CNT_W-1:0] CAP_LIM = CNT_W'(CAP_MAX);
  localparam logic [CNT_W-1:0] CAP_RST =
    (rmq_pkg::CAP_RESET > CAP_MAX) ? CAP_LIM : CNT_W'(rmq_pkg::CAP_RESET);

  logic [CNT_W-1:0]          cap;
  logic [CNT_W-1:0]          head;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          head_next;
  logic [CNT_W-1:0]          count_next;
  logic [rmq_pkg::CMD_W-1:0] cmd_q;
  logic [rmq_pkg::OFF_W-1:0] off_q;
  logic [MSG_WIDTH-1:0]      msg_q;
  logic [CNT_W-1:0]          rd_idx;
  logic [CNT_W-1:0]          hole;
  logic [CNT_W-1:0]          remain;
  logic                      res_ok;
  logic [rmq_pkg::MSG_F_W-1:0] res_msg;

  logic [CNT_W-1:0]     pos_in;
  logic [CNT_W-1:0]     raddr;
  logic [CNT_W-1:0]     push_idx;
  logic [CNT_W-1:0]     off_ext;
  logic [CNT_W-1:0]     count_dec;
  logic                 off_ok;
  logic                 not_empty;
  logic                 has_room;
  logic                 exec_ok;
  logic                 exec_read;
  logic                 push_we;
  logic                 ram_we;
  logic [CNT_W-1:0]     waddr;
  logic [MSG_WIDTH-1:0] wdata;
  logic [MSG_WIDTH-1:0] rdata;

  function automatic logic [CNT_W-1:0] sat_cap(input logic [CNT_W-1:0] v);
    return (v > CAP_LIM) ? CAP_LIM : v;
  endfunction

  // Read port: at accept it fetches the addressed entry; afterwards it walks
  // forward one slot per cycle to feed the remove-at shift.
  assign pos_in = (command == rmq_pkg::CMD_READ_AT || command == rmq_pkg::CMD_REMOVE_AT) ?
                  CNT_W'(offset) : '0;
  assign raddr  = ctl.accept ?
                  rmq_pkg::wrap_idx(SUM_W'(head) + SUM_W'(pos_in), cap) :
                  rmq_pkg::wrap_idx(SUM_W'(rd_idx) + SUM_W'(1), cap);

  assign push_idx  = rmq_pkg::wrap_idx(SUM_W'(head) + SUM_W'(count), cap);
  assign off_ext   = CNT_W'(off_q);
  assign count_dec = count - CNT_W'(1);
  assign off_ok    = off_ext < count;
  assign not_empty = count != '0;
  assign has_room  = count < cap;

  always_comb begin
    head_next  = head;
    count_next = count;
    exec_ok    = 1'b0;
    exec_read  = 1'b0;
    push_we    = 1'b0;
    case (cmd_q)
      rmq_pkg::CMD_PUSH: begin
        if (has_room) begin
          push_we    = 1'b1;
          count_next = count + CNT_W'(1);
          exec_ok    = 1'b1;
        end
      end
      rmq_pkg::CMD_PEEK: begin
        if (not_empty) begin
          exec_ok   = 1'b1;
          exec_read = 1'b1;
        end
      end
      rmq_pkg::CMD_POP: begin
        if (not_empty) begin
          exec_ok    = 1'b1;
          exec_read  = 1'b1;
          count_next = count_dec;
          head_next  = (count_dec == '0) ? '0 :
                       rmq_pkg::wrap_idx(SUM_W'(head) + SUM_W'(1), cap);
        end
      end
      rmq_pkg::CMD_READ_AT: begin
        if (off_ok) begin
          exec_ok   = 1'b1;
          exec_read = 1'b1;
        end
      end
      rmq_pkg::CMD_REMOVE_AT: begin
        if (off_ok) begin
          exec_ok    = 1'b1;
          exec_read  = 1'b1;
          count_next = count_dec;
          if (count_dec == '0) head_next = '0;
        end
      end
      rmq_pkg::CMD_CLEAR: begin
        head_next  = '0;
        count_next = '0;
        exec_ok    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Remove-at shifts only when entries follow the removed one.
  assign sts.need_shift = ctl.exec && (cmd_q == rmq_pkg::CMD_REMOVE_AT) && off_ok &&
                          (count_dec != off_ext);
  assign sts.last_shift = (remain == CNT_W'(1));

  assign ram_we = (ctl.exec && push_we) || ctl.shift;
  assign waddr  = ctl.shift ? hole : push_idx;
  assign wdata  = ctl.shift ? rdata : msg_q;

  rmq_ram #(
    .WIDTH (MSG_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(waddr)),
    .wdata (wdata),
    .raddr (IDX_W'(raddr)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cap   <= CAP_RST;
      head  <= '0;
      count <= '0;
    end else if (cfg_we) begin
      cap   <= sat_cap(cfg_wdata);
      head  <= '0;
      count <= '0;
    end else if (ctl.exec) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= raddr;
    if (ctl.accept) begin
      cmd_q <= command;
      off_q <= offset;
      msg_q <= MSG_WIDTH'(message_in);
    end
    if (ctl.exec) begin
      res_ok  <= exec_ok;
      res_msg <= exec_read ? rmq_pkg::MSG_F_W'(rdata) : '0;
      hole    <= rd_idx;
      remain  <= count_dec - off_ext;
    end
    if (ctl.shift) begin
      hole   <= rd_idx;
      remain <= remain - CNT_W'(1);
    end
    if (ctl.load_out) begin
      ok          <= res_ok;
      message_out <= res_msg;
      count_now   <= count;
    end
  end

  `RMQ_ASSERT(a_count_in_cap, count <= cap, "count exceeds capacity")
  `RMQ_ASSERT(a_head_in_ring, (head < cap) || (head == '0), "head outside ring")
  `RMQ_ASSERT_IMP(a_shift_in_range, ctl.shift, remain != '0 && remain <= count, "shift counter out of range")

endmodule

// ===== hdl/ring_message_queue_remove_at_unit.sv =====
// Ring message queue with random removal: top level.
// Instantiates rmq_ctrl and rmq_dp; depends on rmq_pkg.
//
// Usage:
//   Commands enter on the input channel (in_valid/in_ready with command,
//   offset, message_in). Every command produces exactly one result transfer
//   on the output channel (out_valid/out_ready with ok, message_out,
//   count_now). The capacity register is written through cfg_we/cfg_wdata;
//   the user must write it only while the block is idle, as the block itself
//   does not enforce it. A write also empties the queue. After the input
//   transfer a command runs in the execute state, then in the shift state
//   for a remove-at that has entries behind the removed one, then in the
//   done state, which loads the result into the output registers; no new
//   command is taken before that load. The store has one write and one read
//   port, so the shift moves those entries one entry per cycle.
//   A new command is accepted while a finished result still waits in the
//   output register; the next result waits until that one is taken.
//   Reset empties the queue (head 0, count 0) and sets the capacity to 16,
//   limited to DEPTH. The message store is not cleared: only written
//   entries are ever read, so no clearing pass is needed.
module ring_message_queue_remove_at_unit #(
  parameter int DEPTH     = rmq_pkg::DEPTH_DEF,
  parameter int MSG_WIDTH = rmq_pkg::MSG_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rmq_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rmq_pkg::CMD_W-1:0]     command,
  input  logic [rmq_pkg::OFF_W-1:0]     offset,
  input  logic [rmq_pkg::MSG_F_W-1:0]   message_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ok,
  output logic [rmq_pkg::MSG_F_W-1:0]   message_out,
  output logic [rmq_pkg::CNT_W-1:0]     count_now
);

  rmq_pkg::ctrl_cmd_t ctl;
  rmq_pkg::dp_sts_t   sts;

  rmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  rmq_dp #(
    .DEPTH     (DEPTH),
    .MSG_WIDTH (MSG_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .command     (command),
    .offset      (offset),
    .message_in  (message_in),
    .ok          (ok),
    .message_out (message_out),
    .count_now   (count_now)
  );

endmodule
